/* hdl/wcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted categorical sampler package
// Shared widths, codes, sequencer states and the bin store request type.
// ----------------------------------------------------------------------------
package wcs_pkg;

  // Table geometry.
  localparam int NUM_BINS = 256;
  localparam int ADDR_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // Field and state widths.
  localparam int FUNC_W   = 2;
  localparam int SYM_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int BIN_W    = 32;
  localparam int TOTAL_W  = 40;

  // The fraction times total product is formed from two half-width slices.
  localparam int HALF_W   = TOTAL_W / 2;
  localparam int PROD_W   = FRAC_W + HALF_W;
  localparam int ACC_W    = FRAC_W + TOTAL_W;

  // Prior weight after reset.
  localparam logic [WEIGHT_W-1:0] PRIOR_RESET = 16'd1;

  // Request function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_OBSERVE = 2'd0,
    FUNC_SAMPLE  = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS_WR,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_WALK,
    ST_HOLD
  } state_t;

  // Control bundle from the sequencer to the bin store.
  typedef struct packed {
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [BIN_W-1:0]    wr_data;
    logic                clr;
    logic [WEIGHT_W-1:0] clr_value;
  } bin_req_t;

endpackage

/* hdl/wcs_bin_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted categorical sampler bin store
// Bin weight memory with one valid bit per entry; an entry that has not been
// written since the last clear reads as the prior captured at that clear.
// ----------------------------------------------------------------------------
module wcs_bin_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wcs_pkg::bin_req_t        req,
  output logic [wcs_pkg::BIN_W-1:0] rd_data
);

  logic [wcs_pkg::BIN_W-1:0]    mem [wcs_pkg::NUM_BINS];
  logic [wcs_pkg::NUM_BINS-1:0] valid_r;
  logic [wcs_pkg::WEIGHT_W-1:0] clr_value_r;
  logic [wcs_pkg::BIN_W-1:0]    rd_data_r;
  logic                         rd_valid_r;

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // Valid bits and the value that unwritten entries read as.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      clr_value_r <= wcs_pkg::PRIOR_RESET;
      rd_valid_r  <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r     <= '0;
        clr_value_r <= req.clr_value;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  // Substitute the prior for entries not written since the last clear.
  assign rd_data = rd_valid_r ? rd_data_r : wcs_pkg::BIN_W'(clr_value_r);

endmodule

/* hdl/weighted_categorical_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted categorical sampler
// Roulette-wheel selection over a table of per-symbol weights and their total.
// ----------------------------------------------------------------------------
// Observe reads the bin on acceptance and writes it back in OBS_WR; clear acts on
// acceptance; neither gives a result. Sample forms the two-slice multiply in MUL_LO
// and MUL_HI, which also reads bin 0, then walks one bin per cycle (1 to NUM_BINS)
// through the single memory read port. The result is registered and waits in HOLD while the output is full.
// Synchronous active-low reset sets every bin to a weight of 1, the total to
// NUM_BINS and the prior to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module weighted_categorical_sampler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wcs_pkg::FUNC_W-1:0]   in_func,
  input  logic [wcs_pkg::SYM_W-1:0]    in_symbol_index,
  input  logic [wcs_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [wcs_pkg::FRAC_W-1:0]   in_random_fraction,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wcs_pkg::SYM_W-1:0]    out_chosen_symbol,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wcs_pkg::WEIGHT_W-1:0] cfg_prior_weight
);

  wcs_pkg::state_t              state_r;
  wcs_pkg::state_t              state_nxt;
  wcs_pkg::bin_req_t            bin_req;
  logic [wcs_pkg::BIN_W-1:0]    bin_rd_data;

  logic [wcs_pkg::WEIGHT_W-1:0] prior_r;
  logic [wcs_pkg::TOTAL_W-1:0]  total_r;
  logic [wcs_pkg::ADDR_W-1:0]   addr_r;
  logic [wcs_pkg::WEIGHT_W-1:0] weight_r;
  logic [wcs_pkg::FRAC_W-1:0]   frac_r;
  logic [wcs_pkg::ACC_W-1:0]    acc_r;
  logic [wcs_pkg::TOTAL_W-1:0]  rem_r;
  logic [wcs_pkg::ADDR_W-1:0]   walk_idx_r;
  logic [wcs_pkg::ADDR_W-1:0]   result_r;
  logic                         out_valid_r;
  logic [wcs_pkg::SYM_W-1:0]    out_symbol_r;

  wcs_pkg::func_t               func;
  logic                         in_fire;
  logic                         idx_ok;
  logic [wcs_pkg::TOTAL_W:0]    total_sum;
  logic [wcs_pkg::BIN_W:0]      bin_sum;
  logic [wcs_pkg::BIN_W-1:0]    bin_sat;
  logic [wcs_pkg::HALF_W-1:0]   mul_b;
  logic [wcs_pkg::PROD_W-1:0]   mul_prod;
  logic [wcs_pkg::ACC_W-1:0]    acc_full;
  logic [wcs_pkg::TOTAL_W:0]    walk_diff;
  logic                         walk_hit;
  logic                         walk_last;
  logic                         walk_done;
  logic                         slot_free;

  assign func      = wcs_pkg::func_t'(in_func);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;
  assign idx_ok    = ({1'b0, in_symbol_index} < (wcs_pkg::SYM_W + 1)'(wcs_pkg::NUM_BINS));

  // Saturating total update for an observe request.
  assign total_sum = {1'b0, total_r} + (wcs_pkg::TOTAL_W + 1)'(in_weight);

  // Saturating bin update from the value read back.
  assign bin_sum = {1'b0, bin_rd_data} + (wcs_pkg::BIN_W + 1)'(weight_r);
  assign bin_sat = bin_sum[wcs_pkg::BIN_W] ? '1 : bin_sum[wcs_pkg::BIN_W-1:0];

  // Shared multiplier: low slice of the total first, then the high slice.
  assign mul_b    = (state_r == wcs_pkg::ST_MUL_LO) ? total_r[wcs_pkg::HALF_W-1:0]
                                                   : total_r[wcs_pkg::TOTAL_W-1:wcs_pkg::HALF_W];
  assign mul_prod = wcs_pkg::PROD_W'(frac_r) * wcs_pkg::PROD_W'(mul_b);
  assign acc_full = acc_r + (wcs_pkg::ACC_W'(mul_prod) << wcs_pkg::HALF_W);

  // Walk step: the bin covers the remainder when the remainder minus it is not positive.
  assign walk_diff = {1'b0, rem_r} - (wcs_pkg::TOTAL_W + 1)'(bin_rd_data);
  assign walk_hit  = walk_diff[wcs_pkg::TOTAL_W] || (walk_diff[wcs_pkg::TOTAL_W-1:0] == '0);
  assign walk_last = (walk_idx_r == wcs_pkg::ADDR_W'(wcs_pkg::NUM_BINS - 1));
  assign walk_done = walk_hit || walk_last;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (func)
            wcs_pkg::FUNC_OBSERVE: begin
              if (idx_ok) begin
                state_nxt = wcs_pkg::ST_OBS_WR;
              end
            end
            wcs_pkg::FUNC_SAMPLE: state_nxt = wcs_pkg::ST_MUL_LO;
            default:              state_nxt = wcs_pkg::ST_IDLE;
          endcase
        end
      end
      wcs_pkg::ST_OBS_WR: state_nxt = wcs_pkg::ST_IDLE;
      wcs_pkg::ST_MUL_LO: state_nxt = wcs_pkg::ST_MUL_HI;
      wcs_pkg::ST_MUL_HI: state_nxt = wcs_pkg::ST_WALK;
      wcs_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = slot_free ? wcs_pkg::ST_IDLE : wcs_pkg::ST_HOLD;
        end
      end
      wcs_pkg::ST_HOLD: begin
        if (slot_free) begin
          state_nxt = wcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wcs_pkg::ST_IDLE;
    endcase
  end

  // Output and bin store control.
  always_comb begin
    in_ready          = 1'b0;
    bin_req           = '0;
    bin_req.clr_value = prior_r;
    bin_req.wr_addr   = addr_r;
    bin_req.wr_data   = bin_sat;
    case (state_r)
      wcs_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        bin_req.rd_addr = in_symbol_index[wcs_pkg::ADDR_W-1:0];
        bin_req.rd_en   = in_valid && (func == wcs_pkg::FUNC_OBSERVE) && idx_ok;
        bin_req.clr     = in_valid && (func == wcs_pkg::FUNC_CLEAR);
      end
      wcs_pkg::ST_OBS_WR: begin
        bin_req.wr_en = 1'b1;
      end
      wcs_pkg::ST_MUL_HI: begin
        bin_req.rd_en   = 1'b1;
        bin_req.rd_addr = '0;
      end
      wcs_pkg::ST_WALK: begin
        bin_req.rd_en   = !walk_done;
        bin_req.rd_addr = walk_idx_r + 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Prior weight configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= wcs_pkg::PRIOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prior_r <= cfg_prior_weight;
    end
  end

  // Running total of all bin weights.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= wcs_pkg::TOTAL_W'(wcs_pkg::PRIOR_RESET) * wcs_pkg::TOTAL_W'(wcs_pkg::NUM_BINS);
    end else if (in_fire && (func == wcs_pkg::FUNC_OBSERVE) && idx_ok) begin
      total_r <= total_sum[wcs_pkg::TOTAL_W] ? '1 : total_sum[wcs_pkg::TOTAL_W-1:0];
    end else if (in_fire && (func == wcs_pkg::FUNC_CLEAR)) begin
      total_r <= wcs_pkg::TOTAL_W'(prior_r) * wcs_pkg::TOTAL_W'(wcs_pkg::NUM_BINS);
    end
  end

  // Request payload, product accumulator and walk datapath.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r   <= in_symbol_index[wcs_pkg::ADDR_W-1:0];
      weight_r <= in_weight;
      frac_r   <= in_random_fraction;
    end
    case (state_r)
      wcs_pkg::ST_MUL_LO: begin
        acc_r <= wcs_pkg::ACC_W'(mul_prod);
      end
      wcs_pkg::ST_MUL_HI: begin
        rem_r      <= acc_full[wcs_pkg::ACC_W-1:wcs_pkg::FRAC_W];
        walk_idx_r <= '0;
      end
      wcs_pkg::ST_WALK: begin
        if (walk_done) begin
          result_r <= walk_idx_r;
        end else begin
          rem_r      <= walk_diff[wcs_pkg::TOTAL_W-1:0];
          walk_idx_r <= walk_idx_r + 1'b1;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // Result register; it frees the sequencer while the result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == wcs_pkg::ST_WALK) && walk_done && slot_free) begin
      out_valid_r <= 1'b1;
    end else if ((state_r == wcs_pkg::ST_HOLD) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == wcs_pkg::ST_WALK) && walk_done && slot_free) begin
      out_symbol_r <= wcs_pkg::SYM_W'(walk_idx_r);
    end else if ((state_r == wcs_pkg::ST_HOLD) && slot_free) begin
      out_symbol_r <= wcs_pkg::SYM_W'(result_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_symbol = out_symbol_r;

  // Bin weight table.
  wcs_bin_store u_bin_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (bin_req),
    .rd_data (bin_rd_data)
  );

endmodule
